@@ src/dgc_pkg.sv @@
`default_nettype none

package dgc_pkg;

    // configuration port
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 1'b0,
        REG_SRC_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = 13'd480;

    // geometry
    localparam int TARGET_SIZE = 240;
    localparam int FACTOR_W    = 5;
    localparam int FACTOR_MAX  = 31;
    localparam int CNT_W       = 12;

    // payload widths
    localparam int PIX_W  = 32;
    localparam int CH_W   = 8;
    localparam int LUMA_W = 8;
    localparam int OUT_W  = LUMA_W + 2 * CNT_W;

    // bt.601 weights scaled by 1000
    localparam int COEF_R = 299;
    localparam int COEF_G = 587;
    localparam int COEF_B = 114;
    localparam int SUM_W  = 18;

    // divide by 1000 as multiply by ceil(2^28 / 1000) and shift
    localparam int RECIP_W     = 19;
    localparam int LUMA_SHIFT  = 28;
    localparam logic [RECIP_W-1:0] LUMA_RECIP = 19'd268436;

endpackage

`default_nettype wire

@@ src/decimating_gray_converter.sv @@
// An accepted item on s_* passes through 3 registers (stage 1, stage 2, output) before it shows on m_*.
// Throughput: one item per cycle while m_tready stays high; each stage is freed as soon as the next one can take it.
// Items that fall outside the decimated grid are dropped in the sum stage and give no result.
// Reset (rst_n low, asynchronous): src_width 640, src_height 480, factor 1, counters zero,
// all stages empty.
`default_nettype none

module decimating_gray_converter #(
    parameter int MAX_DIM = 4096
) (
    input  wire                           clk,
    input  wire                           rst_n,
    // configuration writes
    input  wire                           cfg_we,
    input  wire [dgc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [dgc_pkg::CFG_W-1:0]      cfg_wdata,
    // pixel items in
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire [dgc_pkg::PIX_W-1:0]      s_tdata,   // pixel_rgb[31:0]
    // luma items out
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [dgc_pkg::OUT_W-1:0]     m_tdata,   // luma[7:0], out_x[19:8], out_y[31:20]
    output logic                          m_tlast    // frame_end
);

    import dgc_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CW    = ((DIM_W > CFG_W) ? DIM_W : CFG_W) + 2;
    localparam int PH_W  = FACTOR_W + 1;
    localparam int PROD_W = SUM_W + RECIP_W;

    function automatic logic [CW-1:0] eff_dim(input logic [CFG_W-1:0] r);
        logic [CW-1:0] v;
        v = CW'(r);
        if (v == '0)
            return CW'(1);
        if (v > CW'(MAX_DIM))
            return CW'(MAX_DIM);
        return v;
    endfunction

    // configuration registers
    logic [CFG_W-1:0] src_width_reg;
    logic [CFG_W-1:0] src_height_reg;

    // frame geometry latched at frame start
    logic [FACTOR_W-1:0] factor_reg, factor_next;
    logic [CW-1:0]       wlat_reg, wlat_next;
    logic [CW-1:0]       hlat_reg, hlat_next;

    // raster position
    logic [CNT_W-1:0]    src_col_reg, src_col_next;
    logic [CNT_W-1:0]    src_row_reg, src_row_next;
    logic [FACTOR_W-1:0] col_phase_reg, col_phase_next;
    logic [FACTOR_W-1:0] row_phase_reg, row_phase_next;
    logic [CNT_W-1:0]    ox_reg, ox_next;
    logic [CNT_W-1:0]    oy_reg, oy_next;

    // stage 1: accepted item with its position
    logic                s1_valid_reg;
    logic [3*CH_W-1:0]   s1_rgb_reg;
    logic [CNT_W-1:0]    s1_col_reg, s1_row_reg, s1_ox_reg, s1_oy_reg;
    logic [FACTOR_W-1:0] s1_factor_reg;
    logic [CW-1:0]       s1_wlat_reg, s1_hlat_reg;
    logic                s1_pz_reg;

    // stage 2: weighted sum of kept items
    logic                s2_valid_reg;
    logic [SUM_W-1:0]    s2_sum_reg;
    logic [CNT_W-1:0]    s2_ox_reg, s2_oy_reg;
    logic                s2_last_reg;

    // output register
    logic                out_valid_reg;
    logic [LUMA_W-1:0]   out_luma_reg;
    logic [CNT_W-1:0]    out_x_reg, out_y_reg;
    logic                out_last_reg;

    logic out_ready, s2_ready, s1_ready, in_acc;

    logic [CW-1:0]       w_eff, h_eff, big;
    logic [FACTOR_MAX+1:1] ge;
    logic [FACTOR_W-1:0] f_new, f_use;
    logic                frame_start;

    logic [CW-1:0]       s1_col_w, s1_row_w, s1_f_w;
    logic                s1_keep, s1_last;
    logic [SUM_W-1:0]    s1_sum;
    logic [PROD_W-1:0]   s2_prod;

    // stage handshakes: a stage takes an item when empty or when it is passing one on
    assign out_ready = !out_valid_reg || m_tready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_tready  = s1_ready;
    assign in_acc    = s_tvalid && s1_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SRC_WIDTH_RST;
            src_height_reg <= SRC_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_wdata;
                REG_SRC_HEIGHT: src_height_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // decimation factor from the larger dimension, thermometer compare against multiples
    always_comb
    begin
        w_eff = eff_dim(src_width_reg);
        h_eff = eff_dim(src_height_reg);
        big   = (h_eff > w_eff) ? h_eff : w_eff;
        ge    = '0;
        for (int k = 1; k <= FACTOR_MAX; k++)
        begin
            ge[k] = (32'(big) >= 32'(k * TARGET_SIZE));
        end
        f_new = '0;
        for (int k = 1; k <= FACTOR_MAX; k++)
        begin
            if (ge[k] && !ge[k+1])
                f_new = f_new | FACTOR_W'(k);
        end
        if (f_new == '0)
            f_new = FACTOR_W'(1);
    end

    // raster counters and geometry latch
    always_comb
    begin
        frame_start = (src_col_reg == '0) && (src_row_reg == '0);
        f_use       = frame_start ? f_new : factor_reg;
        factor_next = f_use;
        wlat_next   = frame_start ? w_eff : wlat_reg;
        hlat_next   = frame_start ? h_eff : hlat_reg;

        src_col_next   = src_col_reg;
        src_row_next   = src_row_reg;
        col_phase_next = col_phase_reg;
        row_phase_next = row_phase_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;

        if (CW'(src_col_reg) + CW'(1) >= w_eff)
        begin
            src_col_next   = '0;
            col_phase_next = '0;
            ox_next        = '0;
            if (CW'(src_row_reg) + CW'(1) >= h_eff)
            begin
                src_row_next   = '0;
                row_phase_next = '0;
                oy_next        = '0;
            end
            else
            begin
                src_row_next = src_row_reg + CNT_W'(1);
                if (PH_W'(row_phase_reg) + PH_W'(1) >= PH_W'(f_use))
                begin
                    row_phase_next = '0;
                    oy_next        = oy_reg + CNT_W'(1);
                end
                else
                begin
                    row_phase_next = row_phase_reg + FACTOR_W'(1);
                end
            end
        end
        else
        begin
            src_col_next = src_col_reg + CNT_W'(1);
            if (PH_W'(col_phase_reg) + PH_W'(1) >= PH_W'(f_use))
            begin
                col_phase_next = '0;
                ox_next        = ox_reg + CNT_W'(1);
            end
            else
            begin
                col_phase_next = col_phase_reg + FACTOR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg    <= FACTOR_W'(1);
            wlat_reg      <= '0;
            hlat_reg      <= '0;
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            col_phase_reg <= '0;
            row_phase_reg <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
        end
        else if (in_acc)
        begin
            factor_reg    <= factor_next;
            wlat_reg      <= wlat_next;
            hlat_reg      <= hlat_next;
            src_col_reg   <= src_col_next;
            src_row_reg   <= src_row_next;
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
            ox_reg        <= ox_next;
            oy_reg        <= oy_next;
        end
    end

    // stage 1 register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_rgb_reg    <= s_tdata[3*CH_W-1:0];
            s1_col_reg    <= src_col_reg;
            s1_row_reg    <= src_row_reg;
            s1_ox_reg     <= ox_reg;
            s1_oy_reg     <= oy_reg;
            s1_factor_reg <= f_use;
            s1_wlat_reg   <= wlat_next;
            s1_hlat_reg   <= hlat_next;
            s1_pz_reg     <= (col_phase_reg == '0) && (row_phase_reg == '0);
        end
    end

    // keep test inside the decimated frame and weighted channel sum
    always_comb
    begin
        s1_col_w = CW'(s1_col_reg);
        s1_row_w = CW'(s1_row_reg);
        s1_f_w   = CW'(s1_factor_reg);
        s1_keep  = s1_pz_reg
                   && (s1_col_w + s1_f_w <= s1_wlat_reg)
                   && (s1_row_w + s1_f_w <= s1_hlat_reg);
        s1_last  = (s1_col_w + (s1_f_w << 1) > s1_wlat_reg)
                   && (s1_row_w + (s1_f_w << 1) > s1_hlat_reg);
        s1_sum   = SUM_W'(COEF_R) * SUM_W'(s1_rgb_reg[3*CH_W-1:2*CH_W])
                   + SUM_W'(COEF_G) * SUM_W'(s1_rgb_reg[2*CH_W-1:CH_W])
                   + SUM_W'(COEF_B) * SUM_W'(s1_rgb_reg[CH_W-1:0]);
    end

    // stage 2 register, dropped items leave here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg && s1_keep;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_sum_reg  <= s1_sum;
            s2_ox_reg   <= s1_ox_reg;
            s2_oy_reg   <= s1_oy_reg;
            s2_last_reg <= s1_last;
        end
    end

    // divide the sum by 1000
    assign s2_prod = PROD_W'(s2_sum_reg) * PROD_W'(LUMA_RECIP);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s2_valid_reg)
        begin
            out_luma_reg <= s2_prod[LUMA_SHIFT +: LUMA_W];
            out_x_reg    <= s2_ox_reg;
            out_y_reg    <= s2_oy_reg;
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_y_reg, out_x_reg, out_luma_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

@@ verif/decimating_gray_converter_tb.sv @@
`default_nettype none

module decimating_gray_converter_tb;

    import dgc_pkg::*;

    localparam int DIM_LIMIT   = 4096;
    localparam int DRAIN_WAIT  = 8;
    localparam int RANDOM_ITEMS = 1000;
    localparam int MAX_PRINTS  = 40;

    typedef enum int {
        RX_READY,
        RX_PATTERN
    } rx_mode_t;

    typedef struct packed {
        logic [LUMA_W-1:0] luma;
        logic [CNT_W-1:0]  col;
        logic [CNT_W-1:0]  row;
        logic              frame_end;
    } luma_item_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [PIX_W-1:0]     s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tlast;

    // predictor copy of registers and frame state
    logic [CFG_W-1:0]    gray_width  = SRC_WIDTH_RST;
    logic [CFG_W-1:0]    gray_height = SRC_HEIGHT_RST;
    logic [FACTOR_W-1:0] decim_factor = 1;
    logic [12:0]         grid_cols = 0;
    logic [12:0]         grid_rows = 0;
    logic [CNT_W-1:0]    pix_col = 0;
    logic [CNT_W-1:0]    pix_row = 0;
    logic [FACTOR_W-1:0] col_step = 0;
    logic [FACTOR_W-1:0] row_step = 0;

    luma_item_t expected_luma_q[$];

    int       errors = 0;
    int       pixels_sent = 0;
    bit       offering = 0;
    int       burst_left = 0;
    int       hold_req = 0;
    int       hold_left = 0;
    rx_mode_t rx_mode = RX_READY;
    logic [15:0] rx_pattern = 16'hA5C3;
    int       rx_tick = 0;

    decimating_gray_converter #(
        .MAX_DIM(DIM_LIMIT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // register value as the block uses it
    function automatic int unsigned dim_in_range(input logic [CFG_W-1:0] value);
        if (value < 1)
            return 1;
        if (value > DIM_LIMIT)
            return DIM_LIMIT;
        return value;
    endfunction

    // advance the frame state by one pixel and queue its luma item if kept
    task automatic predict_luma(input logic [PIX_W-1:0] pixel);
        int unsigned w;
        int unsigned h;
        int unsigned big;
        int unsigned f;
        int unsigned ox;
        int unsigned oy;
        int unsigned sum;
        luma_item_t item;
        w = dim_in_range(gray_width);
        h = dim_in_range(gray_height);

        // geometry is latched at frame start only
        if (pix_col == 0 && pix_row == 0)
        begin
            big = (h > w) ? h : w;
            f = big / TARGET_SIZE;
            if (f < 1)
                f = 1;
            if (f > FACTOR_MAX)
                f = FACTOR_MAX;
            decim_factor = FACTOR_W'(f);
            grid_cols = 13'(w / f);
            grid_rows = 13'(h / f);
        end

        if (col_step == 0 && row_step == 0)
        begin
            ox = pix_col / decim_factor;
            oy = pix_row / decim_factor;
            if (ox < grid_cols && oy < grid_rows)
            begin
                sum = COEF_R * pixel[23:16] + COEF_G * pixel[15:8] + COEF_B * pixel[7:0];
                item.luma = LUMA_W'(sum / 1000);
                item.col = CNT_W'(ox);
                item.row = CNT_W'(oy);
                item.frame_end = (ox + 1 == grid_cols) && (oy + 1 == grid_rows);
                expected_luma_q = {expected_luma_q, item};
            end
        end

        // raster counters follow the current registers at once
        if (pix_col + 32'd1 >= w)
        begin
            pix_col = '0;
            col_step = '0;
            if (pix_row + 32'd1 >= h)
            begin
                pix_row = '0;
                row_step = '0;
            end
            else
            begin
                pix_row = pix_row + 1'b1;
                row_step = (row_step + 32'd1 >= decim_factor) ? 5'd0 : row_step + 5'd1;
            end
        end
        else
        begin
            pix_col = pix_col + 1'b1;
            col_step = (col_step + 32'd1 >= decim_factor) ? 5'd0 : col_step + 5'd1;
        end
    endtask

    // offer one pixel item and wait until it is taken
    task automatic send_pixel(input logic [PIX_W-1:0] pixel);
        s_tvalid <= 1'b1;
        s_tdata  <= pixel;
        offering = 1;
        do
            @(posedge clk);
        while (!s_tready);
        predict_luma(pixel);
        pixels_sent++;
    endtask

    task automatic stop_offer();
        if (offering)
        begin
            s_tvalid <= 1'b0;
            offering = 0;
        end
    endtask

    task automatic pause(input int cycles);
        stop_offer();
        repeat (cycles) @(posedge clk);
    endtask

    // wait until every luma item has come and the pipeline is empty
    task automatic drain();
        stop_offer();
        while (expected_luma_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // only called while idle
    task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SRC_WIDTH;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_index <= REG_SRC_HEIGHT;
        cfg_wdata <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        gray_width  = w;
        gray_height = h;
    endtask

    // one pixel on a 1x1 frame brings the counters back to frame start
    task automatic rewind_frame();
        set_geometry(13'd1, 13'd1);
        send_pixel($urandom);
        drain();
    endtask

    // random pixels, in bursts with gaps or back to back
    task automatic send_stream(input int count, input bit bursty);
        for (int i = 0; i < count; i++)
        begin
            send_pixel($urandom);
            if (bursty)
            begin
                if (burst_left <= 0)
                begin
                    pause($urandom_range(1, 6));
                    burst_left = $urandom_range(1, 20);
                end
                else
                    burst_left--;
            end
        end
    endtask

    // receiver: long hold-off on request, else ready or a rotating pattern
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (rx_mode == RX_READY)
            m_tready <= 1'b1;
        else
        begin
            m_tready <= rx_pattern[0];
            rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
            rx_tick++;
            if (rx_tick % 48 == 0)
                rx_pattern = 16'($urandom) | 16'd1;
        end
    end

    // compare each luma item with the oldest expectation
    always @(posedge clk)
    begin : check_luma
        luma_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_luma_q.size() == 0)
                report_mismatch($sformatf("unexpected item tdata=%h tlast=%b", m_tdata, m_tlast));
            else
            begin
                want = expected_luma_q.pop_front();
                if (m_tdata[7:0] !== want.luma)
                    report_mismatch($sformatf("luma %0d, want %0d", m_tdata[7:0], want.luma));
                if (m_tdata[19:8] !== want.col)
                    report_mismatch($sformatf("out_x %0d, want %0d", m_tdata[19:8], want.col));
                if (m_tdata[31:20] !== want.row)
                    report_mismatch($sformatf("out_y %0d, want %0d", m_tdata[31:20], want.row));
                if (m_tlast !== want.frame_end)
                    report_mismatch($sformatf("frame_end %b, want %b", m_tlast, want.frame_end));
            end
        end
    end

    // geometry right after reset: 640x480 gives factor 2
    task automatic test_reset_geometry();
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);
        send_pixel(32'h0080_4020);
        drain();
    endtask

    // zero registers act as 1, so every pixel is kept
    task automatic test_pixel_extremes();
        set_geometry(13'd0, 13'd0);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h00FF_0000);
        send_pixel(32'h0000_FF00);
        send_pixel(32'h0000_00FF);
        send_pixel(32'hFF00_0000);
        send_pixel(32'h00FF_FFFF);
        drain();
    endtask

    // values above the dimension limit clamp, large factor
    task automatic test_dimension_clamp();
        set_geometry(13'h1FFF, 13'h1FFF);
        send_pixel($urandom);
        send_pixel($urandom);
        send_pixel($urandom);
        drain();
    endtask

    // frame below the target size passes whole, frame_end on last pixel
    task automatic test_small_frame();
        rewind_frame();
        set_geometry(13'd3, 13'd2);
        send_stream(7, 0);
        drain();
    endtask

    // new size takes effect for row and frame length at once
    task automatic test_midframe_resize();
        set_geometry(13'd4, 13'd4);
        send_stream(4, 0);
        drain();
        set_geometry(13'd2, 13'd2);
        send_stream(3, 0);
        drain();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        set_geometry(13'd1, 13'd1);
        rx_mode = RX_READY;
        hold_req = 300;
        send_stream(60, 0);
        drain();
    endtask

    task automatic test_random_frames();
        int stop_at;
        int kind;
        int count;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        logic [CFG_W-1:0] corner_dims[7];
        corner_dims = '{13'd0, 13'd1, 13'd239, 13'd240, 13'd4096, 13'd4097, 13'h1FFF};
        stop_at = pixels_sent + RANDOM_ITEMS;
        while (pixels_sent < stop_at)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                // small frames, often completed, sometimes resized mid-frame
                w = CFG_W'($urandom_range(0, 12));
                h = CFG_W'($urandom_range(0, 12));
                if ($urandom_range(0, 1))
                    rewind_frame();
                count = $urandom_range(30, 120);
            end
            else if (kind < 85)
            begin
                w = CFG_W'($urandom_range(240, 8191));
                h = CFG_W'($urandom_range(1, 8191));
                rewind_frame();
                count = $urandom_range(60, 200);
            end
            else
            begin
                w = corner_dims[$urandom_range(0, 6)];
                h = corner_dims[$urandom_range(0, 6)];
                rewind_frame();
                count = $urandom_range(20, 80);
            end
            set_geometry(w, h);
            rx_mode = $urandom_range(0, 2) != 0 ? RX_PATTERN : RX_READY;
            burst_left = $urandom_range(1, 20);
            send_stream(count, $urandom_range(0, 3) != 0);
            drain();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_SRC_WIDTH;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_geometry();
        test_pixel_extremes();
        test_dimension_clamp();
        test_small_frame();
        test_midframe_resize();
        test_backpressure();
        test_random_frames();
        drain();

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
src/dgc_pkg.sv
src/decimating_gray_converter.sv
verif/decimating_gray_converter_tb.sv
